[src/dd_odo_pkg.sv]
// ----------------------------------------------------------------------------
// dd_odo_pkg
// shared types, constants and tables of the differential drive odometry block
// ----------------------------------------------------------------------------
package dd_odo_pkg;

  localparam int unsigned PositionBitsDef = 32;
  localparam int unsigned WbW             = 20;
  localparam int unsigned TravW           = 16;
  localparam int unsigned SumW            = TravW + 1;
  localparam int unsigned AngW            = 32;

  localparam logic [WbW-1:0] WheelbaseReset = 20'd76800;
  localparam logic [29:0]    TurnScale      = 30'd683565276;
  localparam logic [13:0]    SmallScale     = 14'd10000;

  // cordic
  localparam int unsigned CsW         = 34;
  localparam int unsigned ZW          = 33;
  localparam int unsigned CordicSteps = 30;
  localparam logic signed [CsW-1:0] CordicStart = 34'sd652032874;

  // multiplier and divider
  localparam int unsigned MulAW = 34;
  localparam int unsigned MulBW = 40;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned DivNW = 48;
  localparam int unsigned DeltaW = 45;

  typedef enum logic [2:0] {
    MUL_DH,
    MUL_R,
    MUL_XS,
    MUL_YS,
    MUL_XA,
    MUL_YA
  } mul_op_e;

  typedef enum logic {
    DIV_DH,
    DIV_R
  } div_op_e;

  typedef enum logic [1:0] {
    COR_MID,
    COR_OLD,
    COR_NEW
  } cor_op_e;

  typedef struct packed {
    logic    capture;
    logic    mul_go;
    mul_op_e mul_op;
    logic    div_go;
    div_op_e div_op;
    logic    cor_go;
    cor_op_e cor_op;
    logic    update;
  } dp_cmd_t;

  typedef struct packed {
    logic straight;
    logic mul_done;
    logic div_done;
    logic cor_done;
  } dp_status_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [29:0] atan_f(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[src/dd_odo_cordic.sv]
// ----------------------------------------------------------------------------
// dd_odo_cordic
// iterative rotation cordic, one step per cycle, gives cos and sin in Q30
// ----------------------------------------------------------------------------
module dd_odo_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               go_i,
  input  logic [dd_odo_pkg::AngW-1:0]        ang_i,
  output logic                               done_o,
  output logic signed [dd_odo_pkg::CsW-1:0]  cos_o,
  output logic signed [dd_odo_pkg::CsW-1:0]  sin_o
);
  import dd_odo_pkg::*;

  logic                  busy_q, done_q;
  logic [4:0]            cnt_q;
  logic [1:0]            quad_q;
  logic signed [CsW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0]  z_q, at;
  logic [AngW-1:0]       ang_p, ru;
  logic [1:0]            quad;

  assign ang_p = ang_i + 32'h2000_0000;
  assign quad  = ang_p[31:30];
  assign ru    = ang_i - {quad, 30'b0};
  assign xs    = x_q >>> cnt_q;
  assign ys    = y_q >>> cnt_q;
  assign at    = signed'({3'b000, atan_f(cnt_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      quad_q <= quad;
      x_q    <= CordicStart;
      y_q    <= '0;
      z_q    <= signed'({ru[31], ru});
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

[src/dd_odo_dp.sv]
// ----------------------------------------------------------------------------
// dd_odo_dp
// pose registers, shift-add multiplier, restoring divider and cordic
// ----------------------------------------------------------------------------
module dd_odo_dp #(
  parameter int unsigned PositionBits = dd_odo_pkg::PositionBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dd_odo_pkg::dp_cmd_t               cmd_i,
  output dd_odo_pkg::dp_status_t            status_o,
  input  logic                              wheelbase_we_i,
  input  logic [dd_odo_pkg::WbW-1:0]        wheelbase_i,
  input  logic signed [dd_odo_pkg::TravW-1:0] left_travel_i,
  input  logic signed [dd_odo_pkg::TravW-1:0] right_travel_i,
  output logic signed [31:0]                pos_x_out_o,
  output logic signed [31:0]                pos_y_out_o,
  output logic [31:0]                       heading_out_o
);
  import dd_odo_pkg::*;

  localparam int unsigned ExtW = 76;
  localparam logic signed [ExtW-1:0] PosHi =
    {{(ExtW - PositionBits + 1){1'b0}}, {(PositionBits - 1){1'b1}}};
  localparam logic signed [ExtW-1:0] PosLo = ~PosHi;

  // configuration and operands
  logic [WbW-1:0]         wb_q, wb_eff;
  logic signed [SumW-1:0] sum_q, diff_q;
  logic [SumW-1:0]        adiff_q;
  logic                   small_q;

  // pose
  logic signed [PositionBits-1:0] pose_x_q, pose_y_q;
  logic [AngW-1:0]                heading_q;
  logic signed [ExtW-1:0]         px_e, py_e, sx, sy, new_x, new_y;

  // intermediate results
  logic [DivNW-1:0]         num_q;
  logic                     sign_q;
  logic [32:0]              dh_q;
  logic signed [MulBW-1:0]  r4_q;
  logic signed [CsW-1:0]    c0_q, s0_q, c1_q, s1_q;
  logic signed [DeltaW-1:0] dx_q, dy_q;

  assign wb_eff = (wb_q == '0) ? WbW'(1) : wb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q      <= WheelbaseReset;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else begin
      if (wheelbase_we_i) begin
        wb_q <= wheelbase_i;
      end
      if (cmd_i.update) begin
        heading_q <= heading_q + dh_q[31:0];
        pose_x_q  <= new_x[PositionBits-1:0];
        pose_y_q  <= new_y[PositionBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sum_q   <= SumW'(left_travel_i) + SumW'(right_travel_i);
      diff_q  <= SumW'(right_travel_i) - SumW'(left_travel_i);
      adiff_q <= (right_travel_i >= left_travel_i)
               ? SumW'(SumW'(right_travel_i) - SumW'(left_travel_i))
               : SumW'(SumW'(left_travel_i) - SumW'(right_travel_i));
    end
    small_q <= ({14'b0, adiff_q} * {17'b0, SmallScale}) < 31'(wb_eff);
  end

  // ---------------- multiplier ----------------
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic [MulAW-1:0]        am_q;
  logic [MulPW-1:0]        prod_q;
  logic                    mneg_q, mbusy_q, mdone_q;
  logic [5:0]              mcnt_q;
  logic [MulAW:0]          madd;
  logic signed [MulPW:0]   pv, pr31, pr32;

  always_comb begin
    case (cmd_i.mul_op)
      MUL_DH: begin
        mul_a = signed'({4'b0, TurnScale});
        mul_b = MulBW'(diff_q);
      end
      MUL_R: begin
        mul_a = signed'({14'b0, wb_eff});
        mul_b = MulBW'(sum_q);
      end
      MUL_XS: begin
        mul_a = c0_q;
        mul_b = MulBW'(sum_q);
      end
      MUL_YS: begin
        mul_a = s0_q;
        mul_b = MulBW'(sum_q);
      end
      MUL_XA: begin
        mul_a = s1_q - s0_q;
        mul_b = r4_q;
      end
      MUL_YA: begin
        mul_a = c0_q - c1_q;
        mul_b = r4_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign madd = {1'b0, prod_q[MulPW-1:MulBW]} + (prod_q[0] ? {1'b0, am_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbusy_q <= 1'b0;
      mdone_q <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      mdone_q <= 1'b0;
      if (cmd_i.mul_go) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        mcnt_q <= mcnt_q + 6'd1;
        if (mcnt_q == 6'(MulBW - 1)) begin
          mbusy_q <= 1'b0;
          mdone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      am_q   <= mul_a[MulAW-1] ? MulAW'(-mul_a) : MulAW'(mul_a);
      prod_q <= {{MulAW{1'b0}}, (mul_b[MulBW-1] ? MulBW'(-mul_b) : MulBW'(mul_b))};
      mneg_q <= mul_a[MulAW-1] ^ mul_b[MulBW-1];
    end else if (mbusy_q) begin
      prod_q <= {madd, prod_q[MulBW-1:1]};
    end
  end

  assign pv   = mneg_q ? -signed'({1'b0, prod_q}) : signed'({1'b0, prod_q});
  assign pr31 = pv + (MulPW+1)'(33'sh0_4000_0000);
  assign pr32 = pv + (MulPW+1)'(33'sh0_8000_0000);

  // ---------------- divider ----------------
  logic [DivNW-1:0] dvd_q, div_num;
  logic [WbW-1:0]   rem_q, den_q, div_den;
  logic [WbW:0]     dsh;
  logic             dge, dbusy_q, ddone_q;
  logic [5:0]       dcnt_q;
  logic [DivNW:0]   qs;

  always_comb begin
    case (cmd_i.div_op)
      DIV_DH: begin
        div_den = wb_eff;
        div_num = num_q + DivNW'(wb_eff >> 1);
      end
      default: begin
        div_den = WbW'(adiff_q);
        div_num = num_q + DivNW'(adiff_q >> 1);
      end
    endcase
  end

  assign dsh = {rem_q, dvd_q[DivNW-1]};
  assign dge = dsh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.div_go) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'(DivNW - 1)) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      dvd_q <= div_num;
      den_q <= div_den;
      rem_q <= '0;
    end else if (dbusy_q) begin
      rem_q <= dge ? WbW'(dsh - {1'b0, den_q}) : dsh[WbW-1:0];
      dvd_q <= {dvd_q[DivNW-2:0], dge};
    end
  end

  assign qs = sign_q ? -{1'b0, dvd_q} : {1'b0, dvd_q};

  // ---------------- cordic ----------------
  logic [AngW-1:0]       cor_ang;
  logic                  cdone;
  logic signed [CsW-1:0] cor_c, cor_s;

  always_comb begin
    case (cmd_i.cor_op)
      COR_MID: cor_ang = heading_q + dh_q[32:1];
      COR_NEW: cor_ang = heading_q + dh_q[31:0];
      default: cor_ang = heading_q;
    endcase
  end

  dd_odo_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.cor_go),
    .ang_i  (cor_ang),
    .done_o (cdone),
    .cos_o  (cor_c),
    .sin_o  (cor_s)
  );

  // ---------------- result capture ----------------
  always_ff @(posedge clk_i) begin
    if (mdone_q) begin
      case (cmd_i.mul_op)
        MUL_DH: begin
          num_q  <= prod_q[DivNW-1:0];
          sign_q <= mneg_q;
        end
        MUL_R: begin
          num_q  <= {prod_q[DivNW-2:0], 1'b0};
          sign_q <= sum_q[SumW-1] ^ diff_q[SumW-1];
        end
        MUL_XS:  dx_q <= {pr31[MulPW], pr31[MulPW:31]};
        MUL_YS:  dy_q <= {pr31[MulPW], pr31[MulPW:31]};
        MUL_XA:  dx_q <= {{2{pr32[MulPW]}}, pr32[MulPW:32]};
        MUL_YA:  dy_q <= {{2{pr32[MulPW]}}, pr32[MulPW:32]};
        default: ;
      endcase
    end
    if (ddone_q) begin
      case (cmd_i.div_op)
        DIV_DH:  dh_q <= qs[32:0];
        default: r4_q <= qs[MulBW-1:0];
      endcase
    end
    if (cdone) begin
      case (cmd_i.cor_op)
        COR_NEW: begin
          c1_q <= cor_c;
          s1_q <= cor_s;
        end
        default: begin
          c0_q <= cor_c;
          s0_q <= cor_s;
        end
      endcase
    end
  end

  // ---------------- pose update ----------------
  assign px_e = ExtW'(pose_x_q);
  assign py_e = ExtW'(pose_y_q);
  assign sx   = px_e + ExtW'(dx_q);
  assign sy   = py_e + ExtW'(dy_q);
  assign new_x = (sx > PosHi) ? PosHi : ((sx < PosLo) ? PosLo : sx);
  assign new_y = (sy > PosHi) ? PosHi : ((sy < PosLo) ? PosLo : sy);

  assign pos_x_out_o   = px_e[31:0];
  assign pos_y_out_o   = py_e[31:0];
  assign heading_out_o = heading_q;

  assign status_o.straight = small_q;
  assign status_o.mul_done = mdone_q;
  assign status_o.div_done = ddone_q;
  assign status_o.cor_done = cdone;

endmodule

[src/dd_odo_ctrl.sv]
// ----------------------------------------------------------------------------
// dd_odo_ctrl
// sequencer: steps the datapath through one odometry update per transaction
// ----------------------------------------------------------------------------
module dd_odo_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output dd_odo_pkg::dp_cmd_t    cmd_o,
  input  dd_odo_pkg::dp_status_t status_i
);
  import dd_odo_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MDH  = 4'd1;
  localparam logic [3:0] ST_DDH  = 4'd2;
  localparam logic [3:0] ST_CMID = 4'd3;
  localparam logic [3:0] ST_MXS  = 4'd4;
  localparam logic [3:0] ST_MYS  = 4'd5;
  localparam logic [3:0] ST_MR   = 4'd6;
  localparam logic [3:0] ST_DR   = 4'd7;
  localparam logic [3:0] ST_COLD = 4'd8;
  localparam logic [3:0] ST_CNEW = 4'd9;
  localparam logic [3:0] ST_MXA  = 4'd10;
  localparam logic [3:0] ST_MYA  = 4'd11;
  localparam logic [3:0] ST_UPD  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       go_q, ovalid_q, ovalid_d;
  logic       slot_free;

  assign slot_free = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.mul_op = MUL_DH;
    cmd_o.div_op = DIV_DH;
    cmd_o.cor_op = COR_OLD;
    ovalid_d     = ovalid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_MDH;
      end
      ST_MDH: begin
        cmd_o.mul_go = go_q;
        if (status_i.mul_done) state_d = ST_DDH;
      end
      ST_DDH: begin
        cmd_o.div_go = go_q;
        if (status_i.div_done) state_d = status_i.straight ? ST_CMID : ST_MR;
      end
      ST_CMID: begin
        cmd_o.cor_go = go_q;
        cmd_o.cor_op = COR_MID;
        if (status_i.cor_done) state_d = ST_MXS;
      end
      ST_MXS: begin
        cmd_o.mul_go = go_q;
        cmd_o.mul_op = MUL_XS;
        if (status_i.mul_done) state_d = ST_MYS;
      end
      ST_MYS: begin
        cmd_o.mul_go = go_q;
        cmd_o.mul_op = MUL_YS;
        if (status_i.mul_done) state_d = ST_UPD;
      end
      ST_MR: begin
        cmd_o.mul_go = go_q;
        cmd_o.mul_op = MUL_R;
        if (status_i.mul_done) state_d = ST_DR;
      end
      ST_DR: begin
        cmd_o.div_go = go_q;
        cmd_o.div_op = DIV_R;
        if (status_i.div_done) state_d = ST_COLD;
      end
      ST_COLD: begin
        cmd_o.cor_go = go_q;
        if (status_i.cor_done) state_d = ST_CNEW;
      end
      ST_CNEW: begin
        cmd_o.cor_go = go_q;
        cmd_o.cor_op = COR_NEW;
        if (status_i.cor_done) state_d = ST_MXA;
      end
      ST_MXA: begin
        cmd_o.mul_go = go_q;
        cmd_o.mul_op = MUL_XA;
        if (status_i.mul_done) state_d = ST_MYA;
      end
      ST_MYA: begin
        cmd_o.mul_go = go_q;
        cmd_o.mul_op = MUL_YA;
        if (status_i.mul_done) state_d = ST_UPD;
      end
      ST_UPD: begin
        if (slot_free) begin
          cmd_o.update = 1'b1;
          ovalid_d     = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      go_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      go_q     <= state_d != state_q;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = ovalid_q;

endmodule

[src/differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry
// dead-reckoning pose integration for a differential drive robot
// ----------------------------------------------------------------------------
// Each transaction carries the left and right wheel travel of one tick and
// returns the updated pose (x, y in 1/256 mm, saturated; heading as a wrapping
// 32-bit fraction of a turn). One item is worked at a time on a shared
// shift-add multiplier, a restoring divider and a 30-step cordic. The update
// waits while a previous result still stalls the output register, and the
// block returns to idle before the next transaction is accepted. The next
// transaction is accepted while the previous result still waits in the output
// register. The wheelbase register is written through wheelbase_we_i; the
// user must write it only while idle, the block itself does not enforce this.
module differential_drive_odometry #(
  parameter int unsigned PositionBits = dd_odo_pkg::PositionBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wheelbase_we_i,
  input  logic [dd_odo_pkg::WbW-1:0]          wheelbase_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [dd_odo_pkg::TravW-1:0] left_travel_i,
  input  logic signed [dd_odo_pkg::TravW-1:0] right_travel_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [31:0]                  pos_x_out_o,
  output logic signed [31:0]                  pos_y_out_o,
  output logic [31:0]                         heading_out_o
);
  import dd_odo_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dd_odo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  dd_odo_dp #(
    .PositionBits (PositionBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .wheelbase_we_i (wheelbase_we_i),
    .wheelbase_i    (wheelbase_i),
    .left_travel_i  (left_travel_i),
    .right_travel_i (right_travel_i),
    .pos_x_out_o    (pos_x_out_o),
    .pos_y_out_o    (pos_y_out_o),
    .heading_out_o  (heading_out_o)
  );

endmodule

[src/dd_odo_checker.sv]
// ----------------------------------------------------------------------------
// dd_odo_checker
// port-level checks of the odometry block, bound to the top level
// ----------------------------------------------------------------------------
module dd_odo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pos_x_out_o,
  input logic [31:0] pos_y_out_o,
  input logic [31:0] heading_out_o
);

  // an accepted transaction keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a transaction");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pos_x_out_o) &&
      $stable(pos_y_out_o) && $stable(heading_out_o))
    else $error("stalled result changed");

  // the pose changes only together with a new result
  a_pose_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(heading_out_o) || !$stable(pos_x_out_o) || !$stable(pos_y_out_o)
      |-> out_valid_o)
    else $error("pose changed without a result");

  // a result only comes from work in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in progress");

endmodule

bind differential_drive_odometry dd_odo_checker u_dd_odo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pos_x_out_o   (pos_x_out_o),
  .pos_y_out_o   (pos_y_out_o),
  .heading_out_o (heading_out_o)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the differential drive odometry block
// ----------------------------------------------------------------------------
// Wheel travel transactions are driven with random gaps and output stalls.
// A scoreboard keeps its own pose and wheelbase, integrates each accepted
// transaction with a bit-true cordic and straight-line or arc update, and
// compares every result field by field. The wheelbase is rewritten between
// phases while the block is idle, its maximum and zero among the settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dd_odo_pkg::*;

  typedef struct {
    bit [31:0] x;
    bit [31:0] y;
    bit [31:0] h;
  } pose_t;

  class pose_scoreboard;
    longint    px, py;
    bit [31:0] heading;
    bit [19:0] wheelbase;
    pose_t     pending[$];
    int        mismatches, checked;
    longint    atan_tab[30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

    function new();
      px = 0; py = 0; heading = 0; wheelbase = 20'd76800;
    endfunction

    function longint rnd_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint rnd_div(longint n, longint d);
      longint an, ad, q;
      an = n < 0 ? -n : n;
      ad = d < 0 ? -d : d;
      q = (an + ad / 2) / ad;
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function void sin_cos(bit [31:0] ang, output longint c, output longint s);
      bit [31:0] q, ru;
      longint z, cx, cy, nx, ny;
      q = ((ang + 32'h2000_0000) >> 30) & 32'd3;
      ru = ang - (q << 30);
      z = longint'(int'(ru));
      cx = 652032874; cy = 0;
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i); ny = cy + (cx >>> i); z -= atan_tab[i];
        end else begin
          nx = cx + (cy >>> i); ny = cy - (cx >>> i); z += atan_tab[i];
        end
        cx = nx; cy = ny;
      end
      case (q)
        0: begin c = cx;  s = cy;  end
        1: begin c = -cy; s = cx;  end
        2: begin c = -cx; s = -cy; end
        default: begin c = cy; s = -cx; end
      endcase
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note(logic signed [15:0] lt, logic signed [15:0] rt);
      longint l, r, wb, sum, diff, adiff, dh, dx, dy, c0, s0, c1, s1, r4;
      bit [31:0] nh, mid;
      pose_t e;
      l = lt; r = rt;
      wb = (wheelbase == 0) ? 1 : longint'(wheelbase);
      sum = l + r; diff = r - l;
      adiff = diff < 0 ? -diff : diff;
      dh = rnd_div(diff * 683565276, wb);
      nh = heading + dh[31:0];
      if (adiff * 10000 < wb) begin
        mid = heading + 32'(dh >>> 1);
        sin_cos(mid, c0, s0);
        dx = rnd_shift(sum * c0, 31);
        dy = rnd_shift(sum * s0, 31);
      end else begin
        r4 = rnd_div(2 * sum * wb, diff);
        sin_cos(heading, c0, s0);
        sin_cos(nh, c1, s1);
        dx = rnd_shift((s1 - s0) * r4, 32);
        dy = rnd_shift((c0 - c1) * r4, 32);
      end
      px = clip(px + dx); py = clip(py + dy); heading = nh;
      e.x = px[31:0]; e.y = py[31:0]; e.h = nh;
      pending.push_back(e);
    endfunction

    function void check(bit [31:0] x, bit [31:0] y, bit [31:0] h);
      pose_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h h=%h", x, y, h);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.x !== x || e.y !== y || e.h !== h) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pose mismatch: exp x=%h y=%h h=%h got x=%h y=%h h=%h",
                   e.x, e.y, e.h, x, y, h);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic wheelbase_we_i = 1'b0;
  logic [WbW-1:0] wheelbase_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [TravW-1:0] left_travel_i = '0;
  logic signed [TravW-1:0] right_travel_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] pos_x_out_o, pos_y_out_o;
  logic [31:0] heading_out_o;

  pose_scoreboard sb = new();
  int idle_in, idle_out, quiet_cycles, wb_settings;

  always #2 clk_i = ~clk_i;

  differential_drive_odometry u_dut (.*);

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check(pos_x_out_o, pos_y_out_o, heading_out_o);
    if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > 20000) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
    out_stall_i <= ($urandom_range(99) < idle_out);
  end

  task automatic send(logic signed [15:0] l, logic signed [15:0] r);
    while ($urandom_range(99) < idle_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_travel_i <= l;
    right_travel_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(l, r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_wheelbase(logic [19:0] v);
    wheelbase_we_i <= 1'b1;
    wheelbase_i <= v;
    @(posedge clk_i);
    wheelbase_we_i <= 1'b0;
    sb.wheelbase = v;
    wb_settings++;
  endtask

  task automatic random_item();
    logic signed [15:0] l, r;
    l = 16'($urandom);
    case ($urandom_range(3))
      0: r = 16'($urandom);
      1: r = l + $signed(16'($urandom_range(14))) - 16'sd7;
      2: begin
        l = $signed(16'($urandom_range(1024))) - 16'sd512;
        r = $signed(16'($urandom_range(1024))) - 16'sd512;
      end
      default: begin
        l = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        r = ($urandom_range(1)) ? 16'sh7fff : (($urandom_range(1)) ? 16'sh8000 : 16'sh0);
      end
    endcase
    send(l, r);
  endtask

  initial begin
    logic [19:0] wb_list[4];
    int in_gap[4], out_gap[4];
    wb_list = '{20'hFFFFF, 20'd256, 20'd0, 20'($urandom_range(256, 1048575))};
    in_gap = '{29, 83, 0, 0};
    out_gap = '{83, 29, 0, 0};
    idle_in = 0; idle_out = 0; wb_settings = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed transactions at the reset wheelbase
    send(0, 0);
    send(16'sh7fff, 16'sh7fff);
    send(16'sh8000, 16'sh8000);
    send(16'sh7fff, 16'sh8000);
    send(16'sh8000, 16'sh7fff);
    send(100, 100);
    send(100, 107);
    send(0, 8);
    send(1, -1);
    send(-1, 0);
    send(256, -256);
    send(16'sh5555, -16'sh5556);
    send(-16'sh5556, 16'sh5555);
    send(-300, -300);
    send(16'sh7fff, 0);
    send(0, 16'sh8000);
    drain();
    write_wheelbase(20'd0);
    send(5, 9);
    send(16'sh7fff, 16'sh8000);
    send(3, 3);
    drain();
    for (int p = 0; p < 4; p++) begin
      idle_in = in_gap[p];
      idle_out = out_gap[p];
      write_wheelbase(wb_list[p]);
      for (int i = 0; i < 370; i++) random_item();
      drain();
    end
    idle_out = 0;
    repeat (400) @(posedge clk_i);
    $display("tb: %0d pose updates checked across %0d wheelbase settings",
             sb.checked, wb_settings + 1);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", sb.mismatches);
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[files.f]
src/dd_odo_pkg.sv
src/dd_odo_cordic.sv
src/dd_odo_dp.sv
src/dd_odo_ctrl.sv
src/differential_drive_odometry.sv
src/dd_odo_checker.sv
tb/tb_top.sv
